[rtl/ils_pkg.sv]
// Shared types and constants for the indexed list store.
// No dependencies; used by ils_ctl and indexed_list_store_core.
package ils_pkg;

   localparam int DEPTH_DEF = 64;
   localparam int DATA_W    = 32;
   localparam int POS_W     = 6;
   localparam int CNT_W     = 7;

   typedef enum logic [2:0] {
      OP_PUSH        = 3'd0,
      OP_POP         = 3'd1,
      OP_REMOVE_HEAD = 3'd2,
      OP_INSERT      = 3'd3,
      OP_REMOVE_AT   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BOUNDS = 2'd1,
      ST_FULL   = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]               op;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] data_in;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data_out;
      status_type               status;
      logic [CNT_W-1:0]         count;
   } rsp_type;

endpackage

[rtl/ils_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ils_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/ils_ctl.sv]
// List sequencer: checks each operation, then shifts entries one at a time
// through the entry RAM with a shared index step unit. Uses ils_pkg, ils_ram.
module ils_ctl #(
   parameter int DEPTH = ils_pkg::DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  ils_pkg::req_type req,
   input  logic             slot_free,
   output logic             idle,
   output logic             done,
   output ils_pkg::rsp_type rsp
);

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW   = $clog2(DEPTH + 1);
   localparam int CMPW = (FW > ils_pkg::POS_W) ? FW : ils_pkg::POS_W;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SETUP  = 6'b000010,
      S_TAKE   = 6'b000100,
      S_STEP   = 6'b001000,
      S_MOVE   = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type                        state_ff, state_in;
   logic [FW-1:0]                    fill_ff, fill_in;
   logic [AW-1:0]                    idx_ff, idx_in;
   logic [AW-1:0]                    k_ff, k_in;
   logic                             ins_ff, ins_in;
   ils_pkg::status_type              status_ff, status_in;
   logic signed [ils_pkg::DATA_W-1:0] result_ff, result_in;

   logic                             ram_we;
   logic [AW-1:0]                    ram_waddr;
   logic [ils_pkg::DATA_W-1:0]       ram_wdata;
   logic [AW-1:0]                    ram_raddr;
   logic [ils_pkg::DATA_W-1:0]       ram_rdata;

   logic                             empty;
   logic                             full;
   logic [CMPW-1:0]                  pos_ext;
   logic [CMPW-1:0]                  fill_ext;
   logic                             rem_last;

   ils_ram #(
      .WIDTH(ils_pkg::DATA_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign empty    = (fill_ff == '0);
   assign full     = (fill_ff == FW'(DEPTH));
   assign pos_ext  = CMPW'(req.position);
   assign fill_ext = CMPW'(fill_ff);
   assign rem_last = ((FW'(idx_ff) + FW'(1)) == fill_ff);

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      k_in      = k_ff;
      ins_in    = ins_ff;
      status_in = status_ff;
      result_in = result_ff;
      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = ram_rdata;
      ram_raddr = idx_ff;
      done      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            status_in = ils_pkg::ST_OK;
            result_in = '0;
            state_in  = S_FINISH;
            case (ils_pkg::op_type'(req.op))
               ils_pkg::OP_PUSH: begin
                  if (full) begin
                     status_in = ils_pkg::ST_FULL;
                  end else begin
                     ins_in   = 1'b1;
                     k_in     = AW'(fill_ff);
                     idx_in   = AW'(fill_ff);
                     state_in = S_STEP;
                  end
               end
               ils_pkg::OP_POP: begin
                  if (empty) begin
                     status_in = ils_pkg::ST_BOUNDS;
                  end else begin
                     ins_in    = 1'b0;
                     idx_in    = AW'(fill_ff - FW'(1));
                     ram_raddr = AW'(fill_ff - FW'(1));
                     state_in  = S_TAKE;
                  end
               end
               ils_pkg::OP_REMOVE_HEAD: begin
                  if (empty) begin
                     status_in = ils_pkg::ST_BOUNDS;
                  end else begin
                     ins_in    = 1'b0;
                     idx_in    = '0;
                     ram_raddr = '0;
                     state_in  = S_TAKE;
                  end
               end
               ils_pkg::OP_INSERT: begin
                  if (pos_ext > fill_ext) begin
                     status_in = ils_pkg::ST_BOUNDS;
                  end else if (full) begin
                     status_in = ils_pkg::ST_FULL;
                  end else begin
                     ins_in   = 1'b1;
                     k_in     = AW'(req.position);
                     idx_in   = AW'(fill_ff);
                     state_in = S_STEP;
                  end
               end
               ils_pkg::OP_REMOVE_AT: begin
                  if (pos_ext >= fill_ext) begin
                     status_in = ils_pkg::ST_BOUNDS;
                  end else begin
                     ins_in    = 1'b0;
                     idx_in    = AW'(req.position);
                     ram_raddr = AW'(req.position);
                     state_in  = S_TAKE;
                  end
               end
               default: begin
                  status_in = ils_pkg::ST_BOUNDS;
               end
            endcase
         end
         S_TAKE: begin
            result_in = ram_rdata;
            state_in  = S_STEP;
         end
         S_STEP: begin
            if (ins_ff) begin
               if (idx_ff == k_ff) begin
                  ram_we    = 1'b1;
                  ram_waddr = k_ff;
                  ram_wdata = req.data_in;
                  fill_in   = fill_ff + FW'(1);
                  state_in  = S_FINISH;
               end else begin
                  ram_raddr = idx_ff - AW'(1);
                  state_in  = S_MOVE;
               end
            end else begin
               if (rem_last) begin
                  fill_in  = fill_ff - FW'(1);
                  state_in = S_FINISH;
               end else begin
                  ram_raddr = idx_ff + AW'(1);
                  state_in  = S_MOVE;
               end
            end
         end
         S_MOVE: begin
            // write the fetched neighbor into the current slot, then advance
            ram_we    = 1'b1;
            ram_waddr = idx_ff;
            ram_wdata = ram_rdata;
            idx_in    = ins_ff ? (idx_ff - AW'(1)) : (idx_ff + AW'(1));
            state_in  = S_STEP;
         end
         S_FINISH: begin
            if (slot_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      k_ff      <= k_in;
      ins_ff    <= ins_in;
      status_ff <= status_in;
      result_ff <= result_in;
   end

   assign idle         = (state_ff == S_IDLE);
   assign rsp.data_out = result_ff;
   assign rsp.status   = status_ff;
   assign rsp.count    = ils_pkg::CNT_W'(fill_ff);

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(DEPTH))
      else $error("fill beyond depth");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_FINISH || state_ff == S_TAKE) |-> !ram_we)
      else $error("entry write outside shift sequence");

   a_fill_change: assert property (@(posedge clock) disable iff (reset)
      !$stable(fill_ff) |-> $past(state_ff) == S_STEP)
      else $error("fill changed outside step");

   a_done_slot: assert property (@(posedge clock) disable iff (reset)
      done |-> (slot_free && state_ff == S_FINISH))
      else $error("result issued without free output slot");
`endif

endmodule

[rtl/indexed_list_store_core.sv]
// Indexed list store top level: request capture, result register, sequencer.
// Uses ils_pkg and ils_ctl (which holds the entry RAM).
//
//   channel | ports                                      | direction
//   req     | req_valid req_ready req_op req_position    | in
//           | req_data_in                                |
//   rsp     | rsp_valid rsp_ready rsp_data_out           | out
//           | rsp_status rsp_count                       |
//
// Each transfer runs setup, then take (pop, remove head, remove at index k), then
// step and move while entries shift, then finish; a rejected or unknown operation
// goes from setup straight to finish. Entries move one at a time through the single
// entry RAM port pair, each read in step and written in move.
// Reset (synchronous, active high) empties the list; no clearing pass.
// A result waiting on rsp_ready holds the sequencer in its final state.
module indexed_list_store_core #(
   parameter int DEPTH = ils_pkg::DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [2:0]                        req_op,
   input  logic [ils_pkg::POS_W-1:0]         req_position,
   input  logic signed [ils_pkg::DATA_W-1:0] req_data_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [ils_pkg::DATA_W-1:0] rsp_data_out,
   output logic [1:0]                        rsp_status,
   output logic [ils_pkg::CNT_W-1:0]         rsp_count
);

   ils_pkg::req_type req_ff, req_in;
   ils_pkg::rsp_type rsp_ff, rsp_in;
   ils_pkg::rsp_type ctl_rsp;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             ctl_idle;
   logic             ctl_done;
   logic             slot_free;

   assign accept    = req_valid && req_ready;
   assign req_ready = ctl_idle;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   ils_ctl #(
      .DEPTH(DEPTH)
   ) u_ctl (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .req      (req_ff),
      .slot_free(slot_free),
      .idle     (ctl_idle),
      .done     (ctl_done),
      .rsp      (ctl_rsp)
   );

   always_comb begin
      req_in = req_ff;
      if (accept) begin
         req_in.op       = req_op;
         req_in.position = req_position;
         req_in.data_in  = req_data_in;
      end
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (ctl_done) begin
         rsp_in       = ctl_rsp;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_ff.data_out;
   assign rsp_status   = rsp_ff.status;
   assign rsp_count    = rsp_ff.count;

endmodule
